>>> hdl/aar_pkg.sv
package aar_pkg;

	localparam int FRAC_BITS = 14;

	localparam int DIR_W  = 16;
	localparam int SQ_W   = 2 * DIR_W - 1;
	localparam int S_W    = 2 * DIR_W;
	localparam int KM_W   = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
	localparam int KMAG_W = KM_W - 1;
	localparam int QB     = KMAG_W + 1;
	localparam int PROD_W = SQ_W + KMAG_W;
	localparam int DW     = S_W + QB;
	localparam int ENT_W  = KM_W + 2;
	localparam int R_W    = 18;
	localparam int NLANE  = 3;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	localparam logic signed [KM_W-1:0]  ONE_K = KM_W'(1) << FRAC_BITS;
	localparam logic signed [ENT_W-1:0] ONE_E = ENT_W'(1) << FRAC_BITS;
	localparam logic signed [ENT_W-1:0] R_MAX = (ENT_W'(1) << (R_W - 1)) - ENT_W'(1);
	localparam logic signed [ENT_W-1:0] R_MIN = -(ENT_W'(1) << (R_W - 1));

	// target sequence: bit 0 picks the Y axis, bit 1 the negative direction
	localparam logic [1:0] TGT_POS_X = 2'd0;
	localparam logic [1:0] TGT_LAST  = 2'd3;

	typedef struct packed {
		logic signed [DIR_W-1:0] ax;
		logic signed [DIR_W-1:0] ay;
		logic signed [DIR_W-1:0] az;
		logic [SQ_W-1:0]         sq_x;
		logic [SQ_W-1:0]         sq_y;
		logic [SQ_W-1:0]         sq_z;
		logic [SQ_W-1:0]         pxz_mag;
		logic [SQ_W-1:0]         pyz_mag;
		logic                    pxz_neg;
		logic                    pyz_neg;
		logic [S_W-1:0]          sx;
		logic [S_W-1:0]          sy;
	} aar_item_t;

	function automatic logic signed [R_W-1:0] sat_r(input logic signed [ENT_W-1:0] x);
		logic signed [ENT_W-1:0] y;
		y = x;
		if (x > R_MAX) y = R_MAX;
		if (x < R_MIN) y = R_MIN;
		return y[R_W-1:0];
	endfunction

endpackage

>>> hdl/axis_alignment_rotations_unit.sv
// Channel   Dir  tdata (low bit up)                  tuser (low bit up)          tlast
// s_axis    in   dir_x[15:0] dir_y[31:16] dir_z[47:32] -                          -
// m_axis    out  r00 r01 r02 r10 r11 r12 r20 r21 r22   target_index[1:0] degenerate last
//                (18 bits each, 168 bits with padding)
//
// One input beat yields four result beats (+X, +Y, -X, -Y), one per cycle while m_axis
// is not stalled, so the sustained input rate is set by the target sequencer that feeds
// the back end. The latency from a taken input beat to m_axis_tvalid is dominated by
// the long-division pipeline (one quotient bit per stage, three lanes).
// arst_n clears all valid bits, queue pointers and the target counter.
// A stall on m_axis freezes the back end; the front and 4-deep queue take beats till full.
module axis_alignment_rotations_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [47:0]  s_axis_tdata,   // dir_x, dir_y, dir_z
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [167:0] m_axis_tdata,   // r00, r01, r02, r10, r11, r12, r20, r21, r22, pad
	output logic [2:0]   m_axis_tuser,   // target_index, degenerate
	output logic         m_axis_tlast
);

	aar_pkg::aar_item_t  push_item, head_item;
	logic                push, full, pop, empty;
	logic [1:0]          target_index;
	logic                degenerate;
	logic signed [aar_pkg::R_W-1:0] r [9];

	// classify: register the beat and form squares, cross terms and both divisors
	aar_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.dir_x    (s_axis_tdata[15:0]),
		.dir_y    (s_axis_tdata[31:16]),
		.dir_z    (s_axis_tdata[47:32]),
		.full     (full),
		.push     (push),
		.item     (push_item)
	);

	// decouple the front from the back end
	aar_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (push_item),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.rd_item (head_item)
	);

	// sequence the four targets, divide, round, saturate
	aar_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (head_item),
		.empty        (empty),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.target_index (target_index),
		.degenerate   (degenerate),
		.last         (m_axis_tlast),
		.r            (r)
	);

	assign m_axis_tuser = {degenerate, target_index};
	assign m_axis_tdata = {6'd0, r[8], r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};

endmodule

>>> hdl/aar_front.sv
module aar_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [aar_pkg::DIR_W-1:0] dir_x,
	input  logic signed [aar_pkg::DIR_W-1:0] dir_y,
	input  logic signed [aar_pkg::DIR_W-1:0] dir_z,
	input  logic                          full,
	output logic                          push,
	output aar_pkg::aar_item_t            item
);

	logic                             valid_s1;
	logic signed [aar_pkg::DIR_W-1:0] ax_s1, ay_s1, az_s1;
	logic signed [aar_pkg::S_W-1:0]   pxx, pyy, pzz, pxz, pyz;

	assign push     = valid_s1 && !full;
	assign in_ready = !valid_s1 || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ax_s1 <= dir_x;
			ay_s1 <= dir_y;
			az_s1 <= dir_z;
		end
	end

	always_comb begin
		pxx = ax_s1 * ax_s1;
		pyy = ay_s1 * ay_s1;
		pzz = az_s1 * az_s1;
		pxz = ax_s1 * az_s1;
		pyz = ay_s1 * az_s1;
		item.ax      = ax_s1;
		item.ay      = ay_s1;
		item.az      = az_s1;
		item.sq_x    = pxx[aar_pkg::SQ_W-1:0];
		item.sq_y    = pyy[aar_pkg::SQ_W-1:0];
		item.sq_z    = pzz[aar_pkg::SQ_W-1:0];
		item.pxz_neg = pxz[aar_pkg::S_W-1];
		item.pyz_neg = pyz[aar_pkg::S_W-1];
		item.pxz_mag = pxz[aar_pkg::S_W-1] ? aar_pkg::SQ_W'(-pxz) : pxz[aar_pkg::SQ_W-1:0];
		item.pyz_mag = pyz[aar_pkg::S_W-1] ? aar_pkg::SQ_W'(-pyz) : pyz[aar_pkg::SQ_W-1:0];
		item.sx      = aar_pkg::S_W'(pyy[aar_pkg::SQ_W-1:0]) + aar_pkg::S_W'(pzz[aar_pkg::SQ_W-1:0]);
		item.sy      = aar_pkg::S_W'(pxx[aar_pkg::SQ_W-1:0]) + aar_pkg::S_W'(pzz[aar_pkg::SQ_W-1:0]);
	end

endmodule

>>> hdl/aar_fifo.sv
module aar_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  aar_pkg::aar_item_t wr_item,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output aar_pkg::aar_item_t rd_item
);

	aar_pkg::aar_item_t           mem_q [aar_pkg::FIFO_DEPTH];
	logic [aar_pkg::FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [aar_pkg::FIFO_AW:0]    count_q;
	logic                         do_push, do_pop;

	assign full    = (count_q == (aar_pkg::FIFO_AW+1)'(aar_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

>>> hdl/aar_back.sv
module aar_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  aar_pkg::aar_item_t               item,
	input  logic                             empty,
	output logic                             pop,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [1:0]                       target_index,
	output logic                             degenerate,
	output logic                             last,
	output logic signed [aar_pkg::R_W-1:0]   r [9]
);

	typedef struct packed {
		logic [1:0]        k;
		logic              deg;
		logic signed [16:0] ev;
		logic signed [16:0] uv;
		logic signed [16:0] wv;
		logic [aar_pkg::S_W-1:0] s;
		logic [aar_pkg::NLANE-1:0] neg;
	} meta_t;

	logic        en;
	logic [1:0]  k_q;
	logic        issue;

	// issue stage
	logic                               is_y, sneg;
	logic signed [aar_pkg::DIR_W-1:0]   u16, e16;
	logic signed [16:0]                 e_x, u_x, w_x;
	logic signed [aar_pkg::KM_W-1:0]    km;
	logic                               kneg, pc_neg;
	meta_t                              meta_i;
	logic [aar_pkg::SQ_W-1:0]           p_i [aar_pkg::NLANE];
	logic [aar_pkg::KMAG_W-1:0]         kmag_i;

	logic                         valid_s1, valid_s2, valid_s3;
	meta_t                        meta_s1, meta_s2, meta_s3;
	logic [aar_pkg::SQ_W-1:0]     p_s1 [aar_pkg::NLANE];
	logic [aar_pkg::KMAG_W-1:0]   kmag_s1;
	logic [aar_pkg::PROD_W-1:0]   prod_s2 [aar_pkg::NLANE];
	logic [aar_pkg::DW-1:0]       rem_s3 [aar_pkg::NLANE];

	// long-division stages, one quotient bit each
	logic                     dv_valid_q [aar_pkg::QB];
	meta_t                    dv_meta_q  [aar_pkg::QB];
	logic [aar_pkg::DW-1:0]   dv_rem_q   [aar_pkg::QB][aar_pkg::NLANE];
	logic [aar_pkg::QB-1:0]   dv_quo_q   [aar_pkg::QB][aar_pkg::NLANE];
	logic [aar_pkg::DW-1:0]   dv_rem_n   [aar_pkg::QB][aar_pkg::NLANE];
	logic [aar_pkg::QB-1:0]   dv_quo_n   [aar_pkg::QB][aar_pkg::NLANE];

	logic signed [aar_pkg::ENT_W-1:0] qv [aar_pkg::NLANE];
	logic signed [aar_pkg::ENT_W-1:0] ent [9];
	logic signed [aar_pkg::ENT_W-1:0] ee, ue, we;
	meta_t                            mf;

	logic                           out_valid_q;
	logic [1:0]                     tgt_q;
	logic                           deg_q;
	logic signed [aar_pkg::R_W-1:0] r_q [9];

	assign en        = !out_valid_q || out_ready;
	assign issue     = !empty;
	assign pop       = en && issue && (k_q == aar_pkg::TGT_LAST);
	assign out_valid = out_valid_q;
	assign target_index = tgt_q;
	assign degenerate   = deg_q;
	assign last         = (tgt_q == aar_pkg::TGT_LAST);
	assign r            = r_q;

	// select the two off-axis components and the on-axis one for target k
	always_comb begin
		is_y = k_q[0];
		sneg = k_q[1];
		u16  = is_y ? item.ax : item.ay;
		e16  = is_y ? item.ay : item.ax;
		e_x  = 17'(e16);
		u_x  = 17'(u16);
		w_x  = 17'(item.az);
		meta_i.k   = k_q;
		meta_i.ev  = sneg ? -e_x : e_x;
		meta_i.uv  = sneg ? -u_x : u_x;
		meta_i.wv  = sneg ? -w_x : w_x;
		meta_i.s   = is_y ? item.sy : item.sx;
		meta_i.deg = (meta_i.s == '0);
		km     = aar_pkg::ONE_K - aar_pkg::KM_W'(meta_i.ev);
		kneg   = km[aar_pkg::KM_W-1];
		kmag_i = kneg ? aar_pkg::KMAG_W'(-km) : km[aar_pkg::KMAG_W-1:0];
		pc_neg = is_y ? item.pxz_neg : item.pyz_neg;
		p_i[0] = is_y ? item.sq_x : item.sq_y;
		p_i[1] = item.sq_z;
		p_i[2] = is_y ? item.pxz_mag : item.pyz_mag;
		// sign of -(p * km)
		meta_i.neg[0] = !kneg;
		meta_i.neg[1] = !kneg;
		meta_i.neg[2] = !(kneg ^ pc_neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= aar_pkg::TGT_POS_X;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			for (int i = 0; i < aar_pkg::QB; i++) dv_valid_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			if (issue) k_q <= k_q + 1'b1;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			dv_valid_q[0] <= valid_s3;
			for (int i = 1; i < aar_pkg::QB; i++) dv_valid_q[i] <= dv_valid_q[i-1];
			out_valid_q <= dv_valid_q[aar_pkg::QB-1];
		end
	end

	always_comb begin
		for (int i = 0; i < aar_pkg::QB; i++) begin
			for (int l = 0; l < aar_pkg::NLANE; l++) begin
				logic [aar_pkg::DW-1:0] src, dsh;
				logic [aar_pkg::QB-1:0] qsrc;
				src  = (i == 0) ? rem_s3[l] : dv_rem_q[(i == 0) ? 0 : i-1][l];
				qsrc = (i == 0) ? '0 : dv_quo_q[(i == 0) ? 0 : i-1][l];
				dsh  = aar_pkg::DW'((i == 0) ? meta_s3.s : dv_meta_q[(i == 0) ? 0 : i-1].s)
					<< (aar_pkg::QB - 1 - i);
				if (src >= dsh) begin
					dv_rem_n[i][l] = src - dsh;
					dv_quo_n[i][l] = {qsrc[aar_pkg::QB-2:0], 1'b1};
				end else begin
					dv_rem_n[i][l] = src;
					dv_quo_n[i][l] = {qsrc[aar_pkg::QB-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s1 <= meta_i;
			kmag_s1 <= kmag_i;
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			for (int l = 0; l < aar_pkg::NLANE; l++) begin
				p_s1[l]    <= p_i[l];
				prod_s2[l] <= aar_pkg::PROD_W'(p_s1[l]) * aar_pkg::PROD_W'(kmag_s1);
				// bias by half the divisor for round-half-away
				rem_s3[l]  <= aar_pkg::DW'(prod_s2[l]) + aar_pkg::DW'(meta_s2.s >> 1);
			end
			dv_meta_q[0] <= meta_s3;
			for (int i = 1; i < aar_pkg::QB; i++) dv_meta_q[i] <= dv_meta_q[i-1];
			for (int i = 0; i < aar_pkg::QB; i++) begin
				for (int l = 0; l < aar_pkg::NLANE; l++) begin
					dv_rem_q[i][l] <= dv_rem_n[i][l];
					dv_quo_q[i][l] <= dv_quo_n[i][l];
				end
			end
			tgt_q <= mf.k;
			deg_q <= mf.deg;
			for (int j = 0; j < 9; j++) r_q[j] <= mf.deg ? '0 : aar_pkg::sat_r(ent[j]);
		end
	end

	// assemble the matrix
	always_comb begin
		mf = dv_meta_q[aar_pkg::QB-1];
		for (int l = 0; l < aar_pkg::NLANE; l++) begin
			logic signed [aar_pkg::ENT_W-1:0] qm;
			qm    = $signed(aar_pkg::ENT_W'(dv_quo_q[aar_pkg::QB-1][l]));
			qv[l] = mf.neg[l] ? -qm : qm;
		end
		ee = aar_pkg::ENT_W'(mf.ev);
		ue = aar_pkg::ENT_W'(mf.uv);
		we = aar_pkg::ENT_W'(mf.wv);
		if (!mf.k[0]) begin
			ent[0] = ee;                   ent[1] = ue;                   ent[2] = we;
			ent[3] = -ue;                  ent[4] = aar_pkg::ONE_E + qv[0]; ent[5] = qv[2];
			ent[6] = -we;                  ent[7] = qv[2];                ent[8] = aar_pkg::ONE_E + qv[1];
		end else begin
			ent[0] = aar_pkg::ONE_E + qv[0]; ent[1] = -ue;                 ent[2] = qv[2];
			ent[3] = ue;                   ent[4] = ee;                   ent[5] = we;
			ent[6] = qv[2];                ent[7] = -we;                  ent[8] = aar_pkg::ONE_E + qv[1];
		end
	end

endmodule
